/* rtl/bbac_pkg.sv */
package bbac_pkg;

    // Image geometry.
    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 480;

    // Field widths.
    localparam int CX_W       = 10;
    localparam int CY_W       = 9;
    localparam int BLUE_W     = 8;
    localparam int AVG_W      = 8;
    localparam int BOXW_W     = 10;
    localparam int BOXH_W     = 9;
    localparam int THR_W      = 8;
    localparam int NFR_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Raster position and box bounds.
    localparam int COL_W = $clog2(IMAGE_WIDTH);
    localparam int ROW_W = $clog2(IMAGE_HEIGHT);
    localparam int XB_W  = $clog2(IMAGE_WIDTH + 1);
    localparam int YB_W  = $clog2(IMAGE_HEIGHT + 1);
    localparam int XS_W  = CX_W + 1;
    localparam int YS_W  = CY_W + 1;

    // Accumulators and divider.
    localparam int SUM_W         = 27;
    localparam int CNT_W         = 19;
    localparam int WSUM_W        = 12;
    localparam int QUO_W         = 12;
    localparam int SHIFT_W       = 4;
    localparam int DVD_W         = CNT_W + QUO_W - 1;
    localparam int AVG_TOP_SHIFT = AVG_W - 1;
    localparam int WIN_TOP_SHIFT = QUO_W - 1;
    localparam int MAX_FRAMES    = 16;

    // Queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register reset values.
    localparam logic [BOXW_W-1:0] BOX_WIDTH_RESET  = 10'd32;
    localparam logic [BOXH_W-1:0] BOX_HEIGHT_RESET = 9'd32;
    localparam logic [THR_W-1:0]  GOOD_THR_RESET   = 8'd250;
    localparam logic [THR_W-1:0]  EMPTY_THR_RESET  = 8'd100;
    localparam logic [NFR_W-1:0]  FRAMES_RESET     = 5'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_WIDTH           = 3'd0,
        REG_BOX_HEIGHT          = 3'd1,
        REG_GOOD_THRESHOLD      = 3'd2,
        REG_EMPTY_THRESHOLD     = 3'd3,
        REG_FRAMES_PER_DECISION = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        VERDICT_NO_EGG = 2'd0,
        VERDICT_GOOD   = 2'd1,
        VERDICT_BAD    = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AVG_DIV,
        ST_ACCUM,
        ST_WIN_DIV
    } back_state_t;

    typedef struct packed {
        logic [SUM_W-1:0] blue_sum;
        logic [CNT_W-1:0] pixel_count;
    } frame_job_t;

    typedef struct packed {
        logic [THR_W-1:0] good_threshold;
        logic [THR_W-1:0] empty_threshold;
        logic [NFR_W-1:0] frames_per_decision;
    } class_cfg_t;

    typedef struct packed {
        logic [AVG_W-1:0] box_average;
        logic             decision_valid;
        verdict_t         verdict;
    } result_t;

endpackage

/* rtl/bbac_front.sv */
module bbac_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            req_type,
    input  logic [bbac_pkg::CX_W-1:0]       focus_x,
    input  logic [bbac_pkg::CY_W-1:0]       focus_y,
    input  logic [bbac_pkg::BLUE_W-1:0]     pixel_blue,
    input  logic                            frame_end,
    input  logic [bbac_pkg::BOXW_W-1:0]     box_width,
    input  logic [bbac_pkg::BOXH_W-1:0]     box_height,
    output logic                            job_push,
    output bbac_pkg::frame_job_t            job_out
);
    import bbac_pkg::*;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CX_W-1:0]  left_reg, left_next;
    logic [XB_W-1:0]  right_reg, right_next;
    logic [CY_W-1:0]  top_reg, top_next;
    logic [YB_W-1:0]  bottom_reg, bottom_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [BOXW_W-2:0] half_x;
    logic [BOXH_W-2:0] half_y;
    logic [XS_W-1:0]   x_end;
    logic [YS_W-1:0]   y_end;
    logic              in_box;
    logic [SUM_W-1:0]  sum_acc;
    logic [CNT_W-1:0]  cnt_acc;

    assign half_x = box_width[BOXW_W-1:1];
    assign half_y = box_height[BOXH_W-1:1];
    assign x_end  = XS_W'(focus_x) + XS_W'(half_x);
    assign y_end  = YS_W'(focus_y) + YS_W'(half_y);

    assign in_box = (XS_W'(col_reg) >= XS_W'(left_reg)) && (XS_W'(col_reg) < XS_W'(right_reg))
                 && (YS_W'(row_reg) >= YS_W'(top_reg)) && (YS_W'(row_reg) < YS_W'(bottom_reg))
                 && (cnt_reg != COUNT_MAX);

    assign sum_acc = in_box ? sum_reg + SUM_W'(pixel_blue) : sum_reg;
    assign cnt_acc = in_box ? cnt_reg + CNT_W'(1) : cnt_reg;

    // The completed frame, including its last pixel, goes to the back end.
    assign job_push            = accept && req_type && frame_end;
    assign job_out.blue_sum    = sum_acc;
    assign job_out.pixel_count = cnt_acc;

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        if (accept)
        begin
            if (!req_type)
            begin
                left_next   = (focus_x > CX_W'(half_x)) ? focus_x - CX_W'(half_x) : '0;
                right_next  = (x_end > XS_W'(IMAGE_WIDTH)) ? XB_W'(IMAGE_WIDTH) : XB_W'(x_end);
                top_next    = (focus_y > CY_W'(half_y)) ? focus_y - CY_W'(half_y) : '0;
                bottom_next = (y_end > YS_W'(IMAGE_HEIGHT)) ? YB_W'(IMAGE_HEIGHT) : YB_W'(y_end);
                col_next    = '0;
                row_next    = '0;
                sum_next    = '0;
                cnt_next    = '0;
            end
            else if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_acc;
                cnt_next = cnt_acc;
                if (col_reg == COL_W'(IMAGE_WIDTH - 1))
                begin
                    col_next = '0;
                    row_next = (row_reg == ROW_W'(IMAGE_HEIGHT - 1)) ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            top_reg    <= '0;
            bottom_reg <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* rtl/bbac_queue.sv */
module bbac_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  bbac_pkg::frame_job_t  wr_data,
    input  logic                  rd_en,
    output bbac_pkg::frame_job_t  rd_data,
    output logic                  full,
    output logic                  avail
);
    import bbac_pkg::*;

    frame_job_t        entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
        return r;
    endfunction

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign avail   = (count_reg != '0);
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // When the queue is empty or full, the read and write pointers must be equal.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
    else $error("queue pointers disagree with fill count");

endmodule

/* rtl/bbac_div.sv */
module bbac_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [bbac_pkg::SUM_W-1:0]      dividend,
    input  logic [bbac_pkg::CNT_W-1:0]      divisor,
    input  logic [bbac_pkg::SHIFT_W-1:0]    top_shift,
    output logic                            done,
    output logic [bbac_pkg::QUO_W-1:0]      quotient
);
    import bbac_pkg::*;

    // Restoring division, one quotient bit per cycle, most significant first.
    // The caller guarantees that the quotient fits in top_shift + 1 bits.
    logic [SUM_W-1:0]   rem_reg, rem_next;
    logic [DVD_W-1:0]   dvs_reg, dvs_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [SHIFT_W-1:0] step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               fits;

    assign fits     = (DVD_W'(rem_reg) >= dvs_reg);
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            dvs_next  = DVD_W'(divisor) << top_shift;
            quo_next  = '0;
            step_next = top_shift;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dvs_reg[SUM_W-1:0];
            end
            quo_next = {quo_reg[QUO_W-2:0], fits};
            dvs_next = dvs_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - SHIFT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
    else $error("divider restarted while busy");

endmodule

/* rtl/bbac_back.sv */
module bbac_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_avail,
    input  bbac_pkg::frame_job_t  job,
    output logic                  job_pop,
    input  bbac_pkg::class_cfg_t  cfg,
    input  logic                  result_pop,
    output logic                  result_valid,
    output bbac_pkg::result_t     result
);
    import bbac_pkg::*;

    back_state_t       state_reg, state_next;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    logic [WSUM_W-1:0] wsum_reg, wsum_next;
    logic [NFR_W-1:0]  wframes_reg, wframes_next;
    logic              out_valid_reg, out_valid_next;
    result_t           result_reg, result_next;

    logic               div_start;
    logic [SUM_W-1:0]   div_dividend;
    logic [CNT_W-1:0]   div_divisor;
    logic [SHIFT_W-1:0] div_shift;
    logic               div_done;
    logic [QUO_W-1:0]   div_quotient;

    logic [NFR_W-1:0]  nframes;
    logic [WSUM_W-1:0] wsum_add;
    logic [NFR_W-1:0]  wframes_add;

    bbac_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .top_shift (div_shift),
        .done      (div_done),
        .quotient  (div_quotient)
    );

    // A window length of zero behaves as one, anything past the maximum as the maximum.
    always_comb
    begin
        if (cfg.frames_per_decision == '0)
        begin
            nframes = NFR_W'(1);
        end
        else if (cfg.frames_per_decision > NFR_W'(MAX_FRAMES))
        begin
            nframes = NFR_W'(MAX_FRAMES);
        end
        else
        begin
            nframes = cfg.frames_per_decision;
        end
    end

    assign wsum_add    = wsum_reg + WSUM_W'(avg_reg);
    assign wframes_add = wframes_reg + NFR_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        avg_next       = avg_reg;
        wsum_next      = wsum_reg;
        wframes_next   = wframes_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        job_pop        = 1'b0;
        div_start      = 1'b0;
        div_dividend   = job.blue_sum;
        div_divisor    = job.pixel_count;
        div_shift      = SHIFT_W'(AVG_TOP_SHIFT);

        if (result_pop)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (job_avail && !out_valid_reg)
                begin
                    job_pop = 1'b1;
                    if (job.pixel_count == '0)
                    begin
                        avg_next   = '0;
                        state_next = ST_ACCUM;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_AVG_DIV;
                    end
                end
            end
            ST_AVG_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = (div_quotient > QUO_W'({AVG_W{1'b1}})) ? {AVG_W{1'b1}}
                                                                       : div_quotient[AVG_W-1:0];
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                wsum_next = wsum_add;
                if (wframes_add >= nframes)
                begin
                    div_start    = 1'b1;
                    div_dividend = SUM_W'(wsum_add);
                    div_divisor  = CNT_W'(nframes);
                    div_shift    = SHIFT_W'(WIN_TOP_SHIFT);
                    state_next   = ST_WIN_DIV;
                end
                else
                begin
                    wframes_next               = wframes_add;
                    out_valid_next             = 1'b1;
                    result_next.box_average    = avg_reg;
                    result_next.decision_valid = 1'b0;
                    result_next.verdict        = VERDICT_NO_EGG;
                    state_next                 = ST_IDLE;
                end
            end
            ST_WIN_DIV:
            begin
                if (div_done)
                begin
                    out_valid_next             = 1'b1;
                    result_next.box_average    = avg_reg;
                    result_next.decision_valid = 1'b1;
                    if (div_quotient > QUO_W'(cfg.good_threshold))
                    begin
                        result_next.verdict = VERDICT_GOOD;
                    end
                    else if (div_quotient < QUO_W'(cfg.empty_threshold))
                    begin
                        result_next.verdict = VERDICT_NO_EGG;
                    end
                    else
                    begin
                        result_next.verdict = VERDICT_BAD;
                    end
                    wsum_next    = '0;
                    wframes_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk)
    begin
        avg_reg    <= avg_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wsum_reg      <= '0;
            wframes_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wsum_reg      <= wsum_next;
            wframes_reg   <= wframes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.decision_valid) |-> (result_reg.verdict == VERDICT_NO_EGG))
    else $error("verdict set on a word that closes no decision window");

    assert property (@(posedge clk) disable iff (!rst_n)
        wframes_reg < NFR_W'(MAX_FRAMES))
    else $error("decision window frame count overran");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AVG_DIV || state_reg == ST_ACCUM || state_reg == ST_WIN_DIV)
        |-> !out_valid_reg)
    else $error("frame in progress while a result word is still waiting");

endmodule

/* rtl/box_blue_average_classifier.sv */
// Box blue-average egg classifier. Push one word per clock: a start word (req_type 0)
// sets the box around focus_x/focus_y, then raster pixels (req_type 1) follow with
// frame_end on the last one. The pixel front end sums the blue values inside the
// clipped box at one pixel per clock and never stalls on its own. Each frame end hands
// its sum and count through a two-entry queue to a back end with one shared bit-serial
// divider: each frame's average, and for a frame that closes a decision window the
// window average as well, is divided out in turn and sent as one result word. full
// rises when two frame ends wait in the queue while the back end is still busy with
// an earlier frame or its result word has not been popped.
// Configuration writes are always ready and belong to idle periods.
module box_blue_average_classifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                req_type,
    input  logic [bbac_pkg::CX_W-1:0]           focus_x,
    input  logic [bbac_pkg::CY_W-1:0]           focus_y,
    input  logic [bbac_pkg::BLUE_W-1:0]         pixel_blue,
    input  logic                                frame_end,
    output logic                                empty,
    input  logic                                pop,
    output logic [bbac_pkg::AVG_W-1:0]          box_average,
    output logic                                decision_valid,
    output logic [1:0]                          verdict,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bbac_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bbac_pkg::*;

    logic [BOXW_W-1:0] box_width_reg, box_width_next;
    logic [BOXH_W-1:0] box_height_reg, box_height_next;
    logic [THR_W-1:0]  good_thr_reg, good_thr_next;
    logic [THR_W-1:0]  empty_thr_reg, empty_thr_next;
    logic [NFR_W-1:0]  frames_reg, frames_next;

    logic       in_accept;
    logic       job_push;
    frame_job_t job_in;
    frame_job_t job_head;
    logic       job_pop;
    logic       job_avail;
    logic       queue_full;
    class_cfg_t class_cfg;
    logic       result_valid;
    result_t    result;

    assign cfg_ready = 1'b1;
    assign full      = queue_full;
    assign in_accept = push && !queue_full;

    always_comb
    begin
        box_width_next  = box_width_reg;
        box_height_next = box_height_reg;
        good_thr_next   = good_thr_reg;
        empty_thr_next  = empty_thr_reg;
        frames_next     = frames_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BOX_WIDTH:           box_width_next  = cfg_data[BOXW_W-1:0];
                REG_BOX_HEIGHT:          box_height_next = cfg_data[BOXH_W-1:0];
                REG_GOOD_THRESHOLD:      good_thr_next   = cfg_data[THR_W-1:0];
                REG_EMPTY_THRESHOLD:     empty_thr_next  = cfg_data[THR_W-1:0];
                REG_FRAMES_PER_DECISION: frames_next     = cfg_data[NFR_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_width_reg  <= BOX_WIDTH_RESET;
            box_height_reg <= BOX_HEIGHT_RESET;
            good_thr_reg   <= GOOD_THR_RESET;
            empty_thr_reg  <= EMPTY_THR_RESET;
            frames_reg     <= FRAMES_RESET;
        end
        else
        begin
            box_width_reg  <= box_width_next;
            box_height_reg <= box_height_next;
            good_thr_reg   <= good_thr_next;
            empty_thr_reg  <= empty_thr_next;
            frames_reg     <= frames_next;
        end
    end

    assign class_cfg.good_threshold      = good_thr_reg;
    assign class_cfg.empty_threshold     = empty_thr_reg;
    assign class_cfg.frames_per_decision = frames_reg;

    bbac_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .req_type   (req_type),
        .focus_x    (focus_x),
        .focus_y    (focus_y),
        .pixel_blue (pixel_blue),
        .frame_end  (frame_end),
        .box_width  (box_width_reg),
        .box_height (box_height_reg),
        .job_push   (job_push),
        .job_out    (job_in)
    );

    bbac_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_head),
        .full    (queue_full),
        .avail   (job_avail)
    );

    bbac_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_avail    (job_avail),
        .job          (job_head),
        .job_pop      (job_pop),
        .cfg          (class_cfg),
        .result_pop   (pop && result_valid),
        .result_valid (result_valid),
        .result       (result)
    );

    assign empty          = !result_valid;
    assign box_average    = result.box_average;
    assign decision_valid = result.decision_valid;
    assign verdict        = result.verdict;

endmodule

/* sim/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bbac_pkg::*;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;
    localparam logic [CNT_W-1:0] COUNT_CAP = '1;
    localparam int IDLE_PCT      = 21;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic              req_type;
        logic [CX_W-1:0]   focus_x;
        logic [CY_W-1:0]   focus_y;
        logic [BLUE_W-1:0] pixel_blue;
        logic              frame_end;
        bit                no_gap;
    } camera_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              push       = 1'b0;
    logic              full;
    logic              req_type   = REQ_START;
    logic [CX_W-1:0]   focus_x    = '0;
    logic [CY_W-1:0]   focus_y    = '0;
    logic [BLUE_W-1:0] pixel_blue = '0;
    logic              frame_end  = 1'b0;
    logic              empty;
    logic              pop        = 1'b0;
    logic [AVG_W-1:0]  box_average;
    logic              decision_valid;
    logic [1:0]        verdict;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Register copies.
    logic [BOXW_W-1:0] box_w_reg  = BOX_WIDTH_RESET;
    logic [BOXH_W-1:0] box_h_reg  = BOX_HEIGHT_RESET;
    logic [THR_W-1:0]  good_reg   = GOOD_THR_RESET;
    logic [THR_W-1:0]  empty_reg  = EMPTY_THR_RESET;
    logic [NFR_W-1:0]  frames_reg = FRAMES_RESET;

    // Frame and window state of the classifier.
    logic [COL_W-1:0]  col           = '0;
    logic [ROW_W-1:0]  row           = '0;
    logic [XB_W-1:0]   left_edge     = '0;
    logic [XB_W-1:0]   right_edge    = '0;
    logic [YB_W-1:0]   top_edge      = '0;
    logic [YB_W-1:0]   bottom_edge   = '0;
    logic [SUM_W-1:0]  blue_total    = '0;
    logic [CNT_W-1:0]  pixels_in_box = '0;
    logic [WSUM_W-1:0] window_total  = '0;
    logic [NFR_W-1:0]  window_count  = '0;

    camera_word_t words_to_push[$];
    camera_word_t word_on_bus;
    result_t      frame_reports_due[$];
    bit           gapless      = 1'b0;
    int           failures     = 0;
    int           reports_seen = 0;

    box_blue_average_classifier DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .focus_x        (focus_x),
        .focus_y        (focus_y),
        .pixel_blue     (pixel_blue),
        .frame_end      (frame_end),
        .empty          (empty),
        .pop            (pop),
        .box_average    (box_average),
        .decision_valid (decision_valid),
        .verdict        (verdict),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Advances the frame and window state by one accepted word and queues the
    // report that a frame end produces.
    task automatic track_word(input camera_word_t w);
        int unsigned half_w, half_h, reach, avg, span, total, win_avg;
        result_t r;
        if (w.req_type == REQ_START)
        begin
            half_w = 32'(box_w_reg >> 1);
            half_h = 32'(box_h_reg >> 1);
            left_edge = (32'(w.focus_x) > half_w) ? XB_W'(32'(w.focus_x) - half_w) : '0;
            reach = 32'(w.focus_x) + half_w;
            right_edge = (reach > IMAGE_WIDTH) ? XB_W'(IMAGE_WIDTH) : XB_W'(reach);
            top_edge = (32'(w.focus_y) > half_h) ? YB_W'(32'(w.focus_y) - half_h) : '0;
            reach = 32'(w.focus_y) + half_h;
            bottom_edge = (reach > IMAGE_HEIGHT) ? YB_W'(IMAGE_HEIGHT) : YB_W'(reach);
            col = '0;
            row = '0;
            blue_total = '0;
            pixels_in_box = '0;
        end
        else
        begin
            if (col >= left_edge && col < right_edge && row >= top_edge &&
                row < bottom_edge && pixels_in_box != COUNT_CAP)
            begin
                blue_total = blue_total + SUM_W'(w.pixel_blue);
                pixels_in_box = pixels_in_box + CNT_W'(1);
            end
            if (col == COL_W'(IMAGE_WIDTH - 1))
            begin
                col = '0;
                row = (row == ROW_W'(IMAGE_HEIGHT - 1)) ? '0 : row + ROW_W'(1);
            end
            else
                col = col + COL_W'(1);

            if (w.frame_end)
            begin
                avg = (pixels_in_box != '0) ? 32'(blue_total) / 32'(pixels_in_box) : 0;
                if (avg > 255)
                    avg = 255;
                col = '0;
                row = '0;
                blue_total = '0;
                pixels_in_box = '0;

                span = 32'(frames_reg);
                if (span == 0)
                    span = 1;
                if (span > MAX_FRAMES)
                    span = MAX_FRAMES;

                total = 32'(window_total) + avg;
                window_count = window_count + NFR_W'(1);
                r.box_average = avg[AVG_W-1:0];
                r.decision_valid = 1'b0;
                r.verdict = VERDICT_NO_EGG;
                if (32'(window_count) >= span)
                begin
                    win_avg = total / span;
                    if (win_avg > 32'(good_reg))
                        r.verdict = VERDICT_GOOD;
                    else if (win_avg < 32'(empty_reg))
                        r.verdict = VERDICT_NO_EGG;
                    else
                        r.verdict = VERDICT_BAD;
                    r.decision_valid = 1'b1;
                    total = 0;
                    window_count = '0;
                end
                window_total = total[WSUM_W-1:0];
                frame_reports_due.push_back(r);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
                track_word(word_on_bus);
            if (!push || !full)
            begin
                if (words_to_push.size() != 0 &&
                    (words_to_push[0].no_gap || $urandom_range(99) >= IDLE_PCT))
                begin
                    word_on_bus = words_to_push.pop_front();
                    push       <= 1'b1;
                    req_type   <= word_on_bus.req_type;
                    focus_x    <= word_on_bus.focus_x;
                    focus_y    <= word_on_bus.focus_y;
                    pixel_blue <= word_on_bus.pixel_blue;
                    frame_end  <= word_on_bus.frame_end;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                reports_seen++;
                if (frame_reports_due.size() == 0)
                begin
                    $error("result word with none expected: box_average %0d", box_average);
                    failures++;
                end
                else
                begin
                    want = frame_reports_due.pop_front();
                    if (box_average !== want.box_average)
                    begin
                        $error("box_average: expected %0d, got %0d",
                               want.box_average, box_average);
                        failures++;
                    end
                    if (decision_valid !== want.decision_valid)
                    begin
                        $error("decision_valid: expected %0d, got %0d",
                               want.decision_valid, decision_valid);
                        failures++;
                    end
                    if (verdict !== want.verdict)
                    begin
                        $error("verdict: expected %0d, got %0d", want.verdict, verdict);
                        failures++;
                    end
                end
            end
            // The receiver never stalls over a stretch of reports.
            pop <= (reports_seen >= 8 && reports_seen < 24) ||
                   ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BOX_WIDTH:           box_w_reg  = value[BOXW_W-1:0];
            REG_BOX_HEIGHT:          box_h_reg  = value[BOXH_W-1:0];
            REG_GOOD_THRESHOLD:      good_reg   = value[THR_W-1:0];
            REG_EMPTY_THRESHOLD:     empty_reg  = value[THR_W-1:0];
            REG_FRAMES_PER_DECISION: frames_reg = value[NFR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned bw, input int unsigned bh,
                              input int unsigned good, input int unsigned low,
                              input int unsigned frames);
        write_reg(REG_BOX_WIDTH, bw);
        write_reg(REG_BOX_HEIGHT, bh);
        write_reg(REG_GOOD_THRESHOLD, good);
        write_reg(REG_EMPTY_THRESHOLD, low);
        write_reg(REG_FRAMES_PER_DECISION, frames);
        @(negedge clk);
    endtask

    // Fields that a word type ignores still carry random bits.
    task automatic add_start(input int unsigned cx, input int unsigned cy);
        camera_word_t w;
        w.req_type   = REQ_START;
        w.focus_x    = cx[CX_W-1:0];
        w.focus_y    = cy[CY_W-1:0];
        w.pixel_blue = BLUE_W'($urandom);
        w.frame_end  = 1'($urandom_range(1));
        w.no_gap     = gapless;
        words_to_push.push_back(w);
    endtask

    task automatic add_pixel(input int unsigned blue, input bit last);
        camera_word_t w;
        w.req_type   = REQ_PIXEL;
        w.focus_x    = CX_W'($urandom);
        w.focus_y    = CY_W'($urandom);
        w.pixel_blue = blue[BLUE_W-1:0];
        w.frame_end  = last;
        w.no_gap     = gapless;
        words_to_push.push_back(w);
    endtask

    // Pixels scatter around a per-frame level so that frame averages land on
    // both sides of the thresholds.
    function automatic int unsigned pick_blue(input int base);
        int v;
        if ($urandom_range(9) == 0)
            return $urandom_range(255);
        v = base + int'($urandom_range(16)) - 8;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v;
    endfunction

    task automatic add_frame(input int len, input int base, input bit closed);
        for (int i = 0; i < len; i++)
            add_pixel(pick_blue(base), closed && i == len - 1);
    endtask

    task automatic add_traffic(input int budget);
        int stop_at, base, pick;
        camera_word_t w;
        stop_at = words_to_push.size() + budget;
        while (words_to_push.size() < stop_at)
        begin
            if ($urandom_range(99) < 10)
            begin
                w.req_type   = 1'($urandom_range(1));
                w.focus_x    = CX_W'($urandom);
                w.focus_y    = CY_W'($urandom);
                w.pixel_blue = BLUE_W'($urandom);
                w.frame_end  = ($urandom_range(3) == 0);
                w.no_gap     = gapless;
                words_to_push.push_back(w);
            end
            else
            begin
                // Some frames reuse the previous box and skip the start word.
                if ($urandom_range(9) != 0)
                begin
                    pick = int'($urandom_range(9));
                    if (pick < 7)
                        add_start($urandom_range(63), $urandom_range(3));
                    else if (pick < 9)
                        add_start($urandom_range(IMAGE_WIDTH - 1),
                                  $urandom_range(IMAGE_HEIGHT - 1));
                    else
                        add_start($urandom_range(1023), $urandom_range(511));
                end
                case ($urandom_range(2))
                    0: base = int'($urandom_range(40));
                    1: base = int'($urandom_range(230, 255));
                    default: base = int'($urandom_range(255));
                endcase
                add_frame(int'($urandom_range(1, 24)), base, $urandom_range(19) != 0);
            end
        end
    endtask

    task automatic settle();
        while (words_to_push.size() != 0 || push || frame_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Pixels before any start see the empty reset box.
        add_pixel(200, 1);
        add_start(0, 0);
        add_pixel(255, 0);
        add_pixel(255, 0);
        add_pixel(0, 1);
        // The box survives a frame end.
        add_pixel(9, 1);
        add_start(1023, 511);
        add_pixel(255, 1);
        add_start(IMAGE_WIDTH - 1, IMAGE_HEIGHT - 1);
        add_pixel(128, 1);
        // A second start abandons the open frame.
        add_start(10, 0);
        add_pixel(1, 0);
        add_start(10, 0);
        add_pixel(254, 1);
        add_start(512, 256);
        add_pixel(7, 1);
        add_traffic(40);
        settle();

        set_config(0, 0, 0, 0, 1);
        add_traffic(30);
        settle();

        set_config(1023, 511, 255, 255, 16);
        gapless = 1'b1;
        add_traffic(60);
        gapless = 1'b0;
        settle();

        // A frame long enough for the column to wrap into the next row.
        set_config(IMAGE_WIDTH, IMAGE_HEIGHT, 200, 50, 0);
        add_start(5, 1);
        add_frame(650, 60, 1'b1);
        add_traffic(30);
        settle();

        set_config(100, 20, 180, 60, 31);
        add_traffic(30);
        settle();

        repeat (4)
        begin
            set_config($urandom_range(1023), $urandom_range(511), $urandom_range(255),
                       $urandom_range(255), $urandom_range(31));
            add_traffic(20);
            settle();
        end

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
